/* sv/asbf_pkg.sv */
// Shared types, constants and the quarter-wave sine table of the blink fader.
package asbf_pkg;

    localparam int SINE_TABLE_DEPTH = 256;
    localparam int SINE_ADDR_W      = $clog2(SINE_TABLE_DEPTH);
    localparam int SINE_POS_W       = SINE_ADDR_W + 2;
    localparam int SINE_IDX_W       = SINE_ADDR_W + 1;

    localparam int TIME_W   = 24;
    localparam int DELTA_W  = 17;
    localparam int LEVEL_W  = 16;
    localparam int RATE_W   = 16;
    localparam int CFG_W    = 16;
    localparam int QUOT_W   = TIME_W + 1;
    localparam int DIV_CNT_W = $clog2(QUOT_W);
    localparam int CFG_INDEX_W = 2;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = DIV_CNT_W'(QUOT_W - 1);
    localparam logic [LEVEL_W-1:0] FULL_OPAQUE   = 16'd32768;
    localparam logic [63:0]        HALF_PI_Q30   = 64'd1686629713;

    localparam logic [CFG_W-1:0] OPACITY_HIGH_RST = 16'd32768;
    localparam logic [CFG_W-1:0] OPACITY_LOW_RST  = 16'd0;
    localparam logic [CFG_W-1:0] RATE_FLOOR_RST   = 16'd256;
    localparam logic [CFG_W-1:0] RATE_CEILING_RST = 16'd2560;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_OPACITY_HIGH = 2'd0,
        CFG_OPACITY_LOW  = 2'd1,
        CFG_RATE_FLOOR   = 2'd2,
        CFG_RATE_CEILING = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADVANCE,
        S_CHECK,
        S_DIVIDE,
        S_CLAMP,
        S_PHASE,
        S_LOOKUP,
        S_SCALE,
        S_BLEND,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic load;
        logic advance;
        logic check;
        logic div_step;
        logic clamp;
        logic phase;
        logic lookup;
        logic scale;
        logic blend;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic tick_running;
        logic blink_end;
        logic div_last;
        logic out_free;
    } dp_status_t;

    typedef logic [LEVEL_W-1:0] sine_rom_t [0:SINE_TABLE_DEPTH];

    // Taylor series of sin(x) in Q2.30 up to x^13, rounded to Q1.15.
    function automatic logic [LEVEL_W-1:0] quarter_sine(input int unsigned i);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        r;
        x    = (HALF_PI_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        if (sum < 0)
        begin
            sum = 64'sd0;
        end
        r = ($unsigned(sum) + 64'd16384) >> 15;
        if (r > 64'(FULL_OPAQUE))
        begin
            r = 64'(FULL_OPAQUE);
        end
        return r[LEVEL_W-1:0];
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++)
        begin
            rom[i] = quarter_sine(i);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

/* sv/asbf_if.sv */
// Valid/ready channel interfaces for the fader's input items and results.
interface asbf_req_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [asbf_pkg::DELTA_W-1:0] delta_time;
    logic [asbf_pkg::TIME_W-1:0]  blink_length;

    modport source (output valid, output action, output delta_time, output blink_length,
                    input ready);
    modport sink (input valid, input action, input delta_time, input blink_length,
                  output ready);
endinterface

interface asbf_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [asbf_pkg::LEVEL_W-1:0] opacity;
    logic                        active;

    modport source (output valid, output opacity, output active, input ready);
    modport sink (input valid, input opacity, input active, output ready);
endinterface

/* sv/asbf_ctrl.sv */
// Sequencing state machine of the blink fader.
module asbf_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  asbf_pkg::dp_status_t  status,
    output asbf_pkg::ctrl_cmd_t   cmd
);

    asbf_pkg::state_t state_reg;
    asbf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= asbf_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            asbf_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = asbf_pkg::S_ADVANCE;
                end
            end
            asbf_pkg::S_ADVANCE:
            begin
                state_next = status.tick_running ? asbf_pkg::S_CHECK : asbf_pkg::S_FINISH;
            end
            asbf_pkg::S_CHECK:
            begin
                state_next = status.blink_end ? asbf_pkg::S_FINISH : asbf_pkg::S_DIVIDE;
            end
            asbf_pkg::S_DIVIDE:
            begin
                if (status.div_last)
                begin
                    state_next = asbf_pkg::S_CLAMP;
                end
            end
            asbf_pkg::S_CLAMP:  state_next = asbf_pkg::S_PHASE;
            asbf_pkg::S_PHASE:  state_next = asbf_pkg::S_LOOKUP;
            asbf_pkg::S_LOOKUP: state_next = asbf_pkg::S_SCALE;
            asbf_pkg::S_SCALE:  state_next = asbf_pkg::S_BLEND;
            asbf_pkg::S_BLEND:  state_next = asbf_pkg::S_FINISH;
            asbf_pkg::S_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = asbf_pkg::S_IDLE;
                end
            end
            default: state_next = asbf_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            asbf_pkg::S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                cmd.load     = in_valid;
            end
            asbf_pkg::S_ADVANCE: cmd.advance  = 1'b1;
            asbf_pkg::S_CHECK:   cmd.check    = 1'b1;
            asbf_pkg::S_DIVIDE:  cmd.div_step = 1'b1;
            asbf_pkg::S_CLAMP:   cmd.clamp    = 1'b1;
            asbf_pkg::S_PHASE:   cmd.phase    = 1'b1;
            asbf_pkg::S_LOOKUP:  cmd.lookup   = 1'b1;
            asbf_pkg::S_SCALE:   cmd.scale    = 1'b1;
            asbf_pkg::S_BLEND:   cmd.blend    = 1'b1;
            asbf_pkg::S_FINISH:  cmd.emit     = status.out_free;
            default:             cmd = '0;
        endcase
    end

endmodule

/* sv/asbf_datapath.sv */
// Timer, reciprocal divider, phase multiplier, sine lookup and blend of the fader.
module asbf_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  asbf_pkg::ctrl_cmd_t                 cmd,
    output asbf_pkg::dp_status_t                status,
    input  logic                                cfg_we,
    input  logic [asbf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [asbf_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_action,
    input  logic [asbf_pkg::DELTA_W-1:0]        in_delta_time,
    input  logic [asbf_pkg::TIME_W-1:0]         in_blink_length,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [asbf_pkg::LEVEL_W-1:0]        out_opacity,
    output logic                                out_active
);

    // Configuration registers.
    logic [asbf_pkg::CFG_W-1:0] high_reg;
    logic [asbf_pkg::CFG_W-1:0] low_reg;
    logic [asbf_pkg::CFG_W-1:0] floor_reg;
    logic [asbf_pkg::CFG_W-1:0] ceiling_reg;

    // Block state.
    logic [asbf_pkg::TIME_W-1:0]  elapsed_reg;
    logic [asbf_pkg::TIME_W-1:0]  length_reg;
    logic                         running_reg;
    logic [asbf_pkg::LEVEL_W-1:0] level_reg;

    // Item and working registers.
    logic                          action_reg;
    logic [asbf_pkg::DELTA_W-1:0]  delta_reg;
    logic [asbf_pkg::TIME_W-1:0]   blen_reg;
    logic [asbf_pkg::TIME_W-1:0]   divisor_reg;
    logic [asbf_pkg::TIME_W-1:0]   div_rem_reg;
    logic [asbf_pkg::QUOT_W-1:0]   div_quot_reg;
    logic [asbf_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [asbf_pkg::RATE_W-1:0]   rate_reg;
    logic [asbf_pkg::TIME_W-1:0]   frac_reg;
    logic [asbf_pkg::LEVEL_W-1:0]  sine_reg;
    logic                          neg_reg;
    logic signed [33:0]            wave_reg;

    logic                         out_valid_reg;
    logic [asbf_pkg::LEVEL_W-1:0] out_opacity_reg;
    logic                         out_active_reg;

    logic [asbf_pkg::TIME_W:0]        elapsed_sum;
    logic [asbf_pkg::TIME_W-1:0]      elapsed_sat;
    logic [asbf_pkg::TIME_W:0]        remain_diff;
    logic [asbf_pkg::TIME_W:0]        div_shift;
    logic [asbf_pkg::TIME_W+1:0]      div_diff;
    logic                             div_fits;
    logic [asbf_pkg::RATE_W-1:0]      rate_clamped;
    logic [asbf_pkg::TIME_W+asbf_pkg::RATE_W-1:0] phase_prod;
    logic [asbf_pkg::SINE_POS_W-1:0]  sine_pos;
    logic [asbf_pkg::SINE_ADDR_W-1:0] sine_k;
    logic [asbf_pkg::SINE_IDX_W-1:0]  sine_idx;
    logic signed [16:0]               sine_signed;
    logic signed [16:0]               span;
    logic signed [34:0]               blend_sum;
    logic signed [18:0]               blend_level;
    logic [asbf_pkg::LEVEL_W-1:0]     blend_sat;

    assign elapsed_sum = {1'b0, elapsed_reg} + (asbf_pkg::TIME_W + 1)'(delta_reg);
    assign elapsed_sat = elapsed_sum[asbf_pkg::TIME_W] ? '1 : elapsed_sum[asbf_pkg::TIME_W-1:0];
    assign remain_diff = {1'b0, length_reg} - {1'b0, elapsed_reg};

    assign div_shift = {div_rem_reg, div_quot_reg[asbf_pkg::QUOT_W-1]};
    assign div_diff  = {1'b0, div_shift} - {2'b00, divisor_reg};
    assign div_fits  = !div_diff[asbf_pkg::TIME_W+1];

    always_comb
    begin
        if (div_quot_reg < asbf_pkg::QUOT_W'(floor_reg))
        begin
            rate_clamped = floor_reg;
        end
        else if (div_quot_reg < asbf_pkg::QUOT_W'(ceiling_reg))
        begin
            rate_clamped = div_quot_reg[asbf_pkg::RATE_W-1:0];
        end
        else
        begin
            rate_clamped = ceiling_reg;
        end
    end

    assign phase_prod = elapsed_reg * rate_reg;

    assign sine_pos = frac_reg[asbf_pkg::TIME_W-1 -: asbf_pkg::SINE_POS_W];
    assign sine_k   = sine_pos[asbf_pkg::SINE_ADDR_W-1:0];
    assign sine_idx = sine_pos[asbf_pkg::SINE_ADDR_W]
                    ? asbf_pkg::SINE_IDX_W'(asbf_pkg::SINE_TABLE_DEPTH) - {1'b0, sine_k}
                    : {1'b0, sine_k};

    assign sine_signed = neg_reg ? -$signed({1'b0, sine_reg}) : $signed({1'b0, sine_reg});
    assign span        = $signed({1'b0, high_reg}) - $signed({1'b0, low_reg});

    assign blend_sum = $signed({2'b00, ({1'b0, high_reg} + {1'b0, low_reg}), 15'd0})
                     + 35'(wave_reg) + 35'sd32768;
    assign blend_level = blend_sum[34:16];

    always_comb
    begin
        if (blend_level < 0)
        begin
            blend_sat = '0;
        end
        else if (blend_level > $signed({3'b000, asbf_pkg::FULL_OPAQUE}))
        begin
            blend_sat = asbf_pkg::FULL_OPAQUE;
        end
        else
        begin
            blend_sat = blend_level[asbf_pkg::LEVEL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_reg    <= asbf_pkg::OPACITY_HIGH_RST;
            low_reg     <= asbf_pkg::OPACITY_LOW_RST;
            floor_reg   <= asbf_pkg::RATE_FLOOR_RST;
            ceiling_reg <= asbf_pkg::RATE_CEILING_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                asbf_pkg::CFG_OPACITY_HIGH: high_reg    <= cfg_data;
                asbf_pkg::CFG_OPACITY_LOW:  low_reg     <= cfg_data;
                asbf_pkg::CFG_RATE_FLOOR:   floor_reg   <= cfg_data;
                asbf_pkg::CFG_RATE_CEILING: ceiling_reg <= cfg_data;
                default:                    high_reg    <= high_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
            length_reg  <= '0;
            running_reg <= 1'b0;
            level_reg   <= asbf_pkg::FULL_OPAQUE;
        end
        else
        begin
            if (cmd.advance)
            begin
                if (action_reg)
                begin
                    running_reg <= 1'b1;
                    length_reg  <= blen_reg;
                end
                else if (!running_reg)
                begin
                    elapsed_reg <= '0;
                end
                else
                begin
                    elapsed_reg <= elapsed_sat;
                end
            end
            if (cmd.check && status.blink_end)
            begin
                running_reg <= 1'b0;
                level_reg   <= asbf_pkg::FULL_OPAQUE;
            end
            if (cmd.blend)
            begin
                level_reg <= blend_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= in_action;
            delta_reg  <= in_delta_time;
            blen_reg   <= in_blink_length;
        end
        if (cmd.check)
        begin
            divisor_reg  <= remain_diff[asbf_pkg::TIME_W-1:0];
            div_rem_reg  <= '0;
            div_quot_reg <= asbf_pkg::QUOT_W'(1) << asbf_pkg::TIME_W;
            div_cnt_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            div_rem_reg  <= div_fits ? div_diff[asbf_pkg::TIME_W-1:0]
                                     : div_shift[asbf_pkg::TIME_W-1:0];
            div_quot_reg <= {div_quot_reg[asbf_pkg::QUOT_W-2:0], div_fits};
            div_cnt_reg  <= div_cnt_reg + 1'b1;
        end
        if (cmd.clamp)
        begin
            rate_reg <= rate_clamped;
        end
        if (cmd.phase)
        begin
            frac_reg <= phase_prod[asbf_pkg::TIME_W-1:0];
        end
        if (cmd.lookup)
        begin
            sine_reg <= asbf_pkg::SINE_ROM[sine_idx];
            neg_reg  <= sine_pos[asbf_pkg::SINE_POS_W-1];
        end
        if (cmd.scale)
        begin
            wave_reg <= span * sine_signed;
        end
        if (cmd.emit)
        begin
            out_opacity_reg <= level_reg;
            out_active_reg  <= running_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.tick_running = !action_reg && running_reg;
    assign status.blink_end    = remain_diff[asbf_pkg::TIME_W]
                              || (remain_diff[asbf_pkg::TIME_W-1:0] == '0);
    assign status.div_last     = (div_cnt_reg == asbf_pkg::DIV_LAST_STEP);
    assign status.out_free     = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign out_opacity = out_opacity_reg;
    assign out_active  = out_active_reg;

endmodule

/* sv/accelerating_sine_blink_fader_unit.sv */
// Top level of the accelerating sine blink fader.
// Each request beat is a trigger or a frame tick and yields exactly one response beat
// with the opacity and the active flag after it. The unit works on one beat at a time.
// A trigger or an idle tick runs the advance and finish states before the next ready; one
// that ends the blink adds the check state; one that computes the wave adds the radix-2
// reciprocal divider for the blink rate, one quotient bit per cycle, and the clamp,
// phase, lookup, scale and blend states. A finished response sits in an output
// register, so the next request is taken while it waits; a following result waits
// for that register to drain. Configuration writes take effect at once and belong in idle periods.
module accelerating_sine_blink_fader_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    asbf_req_if.sink                         req,
    asbf_rsp_if.source                       rsp,
    input  logic                             cfg_we,
    input  logic [asbf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [asbf_pkg::CFG_W-1:0]       cfg_data
);

    asbf_pkg::ctrl_cmd_t  cmd;
    asbf_pkg::dp_status_t status;

    asbf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .status   (status),
        .cmd      (cmd)
    );

    asbf_datapath u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_action       (req.action),
        .in_delta_time   (req.delta_time),
        .in_blink_length (req.blink_length),
        .out_valid       (rsp.valid),
        .out_ready       (rsp.ready),
        .out_opacity     (rsp.opacity),
        .out_active      (rsp.active)
    );

    assign req.ready = cmd.in_ready;

endmodule

/* sv/asbf_checker.sv */
// Port-level assertions for the blink fader and their attachment to the top level.
module asbf_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [asbf_pkg::LEVEL_W-1:0] rsp_opacity,
    input logic                         rsp_active
);

    // A response that is not taken keeps its content.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_opacity) && $stable(rsp_active))
    else $error("stalled response beat changed");

    // The opacity never exceeds fully opaque.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_opacity <= asbf_pkg::FULL_OPAQUE)
    else $error("opacity above full scale");

    // Outside a blink the level is always fully opaque.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_active |-> rsp_opacity == asbf_pkg::FULL_OPAQUE)
    else $error("inactive beat with partial opacity");

    // One beat is worked on at a time, so ready drops after an acceptance.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("second request taken while busy");

endmodule

bind accelerating_sine_blink_fader_unit asbf_checker u_asbf_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_opacity (rsp.opacity),
    .rsp_active  (rsp.active)
);

/* tb/tb_top.sv */
// Self-checking testbench of the accelerating sine blink fader with its own fixed-point predictor.
module tb_top;

    localparam int          CYCLE_LIMIT   = 2000000;
    localparam int          PHASE_ITEMS   = 200;
    localparam int          RAND_PHASES   = 9;
    localparam int          DRAIN_CYCLES  = 40;
    localparam int          HOLD_CYCLES   = 250;
    localparam logic [63:0] QUARTER_TURN  = 64'd1686629713;
    localparam int          TIMER_MAX     = (1 << asbf_pkg::TIME_W) - 1;
    localparam int          DELTA_MAX     = 65536;

    typedef struct {
        logic                         action;
        logic [asbf_pkg::DELTA_W-1:0] delta_time;
        logic [asbf_pkg::TIME_W-1:0]  blink_length;
    } fader_in_t;

    typedef struct {
        logic [asbf_pkg::LEVEL_W-1:0] opacity;
        logic                         active;
    } fader_out_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    asbf_pkg::cfg_index_t       cfg_index;
    logic [asbf_pkg::CFG_W-1:0] cfg_data;

    asbf_req_if req_if();
    asbf_rsp_if rsp_if();

    accelerating_sine_blink_fader_unit u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [asbf_pkg::CFG_W-1:0]   wave_hi    = asbf_pkg::OPACITY_HIGH_RST;
    logic [asbf_pkg::CFG_W-1:0]   wave_lo    = asbf_pkg::OPACITY_LOW_RST;
    logic [asbf_pkg::CFG_W-1:0]   rate_lo    = asbf_pkg::RATE_FLOOR_RST;
    logic [asbf_pkg::CFG_W-1:0]   rate_hi    = asbf_pkg::RATE_CEILING_RST;
    logic [asbf_pkg::TIME_W-1:0]  timer      = '0;
    logic [asbf_pkg::TIME_W-1:0]  blink_len  = '0;
    logic                         blinking   = 1'b0;
    logic [asbf_pkg::LEVEL_W-1:0] fade_level = asbf_pkg::FULL_OPAQUE;

    fader_in_t  stim_q[$];
    fader_out_t expected_levels[$];

    logic calm = 1'b0;
    int   errors = 0;
    int   beats = 0;
    int   queued = 0;
    int   cycles = 0;
    int   send_gap = 0;
    int   recv_stall = 0;
    int   hold_left = 0;
    int   settings = 1;
    int   n_trigger = 0;
    int   n_wave = 0;
    int   n_end = 0;
    int   n_idle = 0;
    int   n_sat = 0;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic int quarter_wave(input int unsigned i);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] r;
        longint      acc;
        x    = (QUARTER_TURN * 64'(i)) / 64'(asbf_pkg::SINE_TABLE_DEPTH);
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 6; n++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
            begin
                acc = acc - longint'(term);
            end
            else
            begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        r = (64'(acc) + 64'd16384) >> 15;
        return (r > 64'd32768) ? 32768 : int'(r);
    endfunction

    function automatic int wave_sample(input logic [asbf_pkg::TIME_W-1:0] frac);
        logic [63:0] pos;
        int unsigned quad;
        int unsigned k;
        pos  = (64'(frac) * 64'(4 * asbf_pkg::SINE_TABLE_DEPTH)) >> 24;
        quad = int'((pos / 64'(asbf_pkg::SINE_TABLE_DEPTH)) % 64'd4);
        k    = int'(pos % 64'(asbf_pkg::SINE_TABLE_DEPTH));
        case (quad)
            0: return quarter_wave(k);
            1: return quarter_wave(asbf_pkg::SINE_TABLE_DEPTH - k);
            2: return -quarter_wave(k);
            default: return -quarter_wave(asbf_pkg::SINE_TABLE_DEPTH - k);
        endcase
    endfunction

    function automatic logic [asbf_pkg::LEVEL_W-1:0] blend_wave(input int s);
        longint num;
        longint v;
        num = (longint'(wave_hi) + longint'(wave_lo)) * 32768
            + (longint'(wave_hi) - longint'(wave_lo)) * longint'(s) + 32768;
        v = num >>> 16;
        if (v < 0)
        begin
            return '0;
        end
        if (v > 32768)
        begin
            return asbf_pkg::FULL_OPAQUE;
        end
        return v[asbf_pkg::LEVEL_W-1:0];
    endfunction

    function automatic fader_out_t step_fader(input fader_in_t it);
        fader_out_t                  o;
        logic [asbf_pkg::TIME_W:0]   total;
        logic [asbf_pkg::TIME_W-1:0] remaining;
        logic [asbf_pkg::TIME_W:0]   raw;
        logic [asbf_pkg::CFG_W-1:0]  rate;
        logic [63:0]                 prod;
        if (it.action)
        begin
            blinking  = 1'b1;
            blink_len = it.blink_length;
            n_trigger++;
        end
        else if (!blinking)
        begin
            timer = '0;
            n_idle++;
        end
        else
        begin
            total = {1'b0, timer} + (asbf_pkg::TIME_W + 1)'(it.delta_time);
            if (total > TIMER_MAX)
            begin
                timer = '1;
                n_sat++;
            end
            else
            begin
                timer = total[asbf_pkg::TIME_W-1:0];
            end
            if (timer >= blink_len)
            begin
                blinking   = 1'b0;
                fade_level = asbf_pkg::FULL_OPAQUE;
                n_end++;
            end
            else
            begin
                remaining = blink_len - timer;
                raw = (25'h1000000) / {1'b0, remaining};
                if (raw < rate_lo)
                begin
                    rate = rate_lo;
                end
                else if (raw < rate_hi)
                begin
                    rate = raw[asbf_pkg::CFG_W-1:0];
                end
                else
                begin
                    rate = rate_hi;
                end
                prod       = 64'(timer) * 64'(rate);
                fade_level = blend_wave(wave_sample(prod[asbf_pkg::TIME_W-1:0]));
                n_wave++;
            end
        end
        o.opacity = fade_level;
        o.active  = blinking;
        return o;
    endfunction

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    always @(posedge clk)
    begin : send_proc
        fader_in_t  nxt;
        fader_in_t  seen;
        fader_out_t want;
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
            begin
                seen.action       = req_if.action;
                seen.delta_time   = req_if.delta_time;
                seen.blink_length = req_if.blink_length;
                want = step_fader(seen);
                expected_levels.push_back(want);
            end
            if (!req_if.valid || req_if.ready)
            begin
                if (send_gap > 0 || stim_q.size() == 0)
                begin
                    if (send_gap > 0)
                    begin
                        send_gap--;
                    end
                    req_if.valid <= 1'b0;
                end
                else
                begin
                    nxt = stim_q.pop_front();
                    req_if.valid        <= 1'b1;
                    req_if.action       <= nxt.action;
                    req_if.delta_time   <= nxt.delta_time;
                    req_if.blink_length <= nxt.blink_length;
                    send_gap = calm ? 0 : idle_gap();
                end
            end
        end
    end

    always @(posedge clk)
    begin : recv_proc
        fader_out_t want;
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                beats++;
                if (expected_levels.size() == 0)
                begin
                    errors++;
                    $display("%0t: expected no beat, actual opacity %0d active %0b",
                             $time, rsp_if.opacity, rsp_if.active);
                end
                else
                begin
                    want = expected_levels.pop_front();
                    if (rsp_if.opacity !== want.opacity)
                    begin
                        errors++;
                        $display("%0t: opacity expected %0d actual %0d",
                                 $time, want.opacity, rsp_if.opacity);
                    end
                    if (rsp_if.active !== want.active)
                    begin
                        errors++;
                        $display("%0t: active expected %0b actual %0b",
                                 $time, want.active, rsp_if.active);
                    end
                end
                if (beats % 400 == 100)
                begin
                    hold_left = HOLD_CYCLES;
                end
                else if (!calm)
                begin
                    recv_stall = idle_gap();
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic push_item(input logic act, input int unsigned dt, input int unsigned len);
        fader_in_t it;
        it.action       = act;
        it.delta_time   = dt[asbf_pkg::DELTA_W-1:0];
        it.blink_length = len[asbf_pkg::TIME_W-1:0];
        stim_q.push_back(it);
        queued++;
    endtask

    task automatic push_tick(input int unsigned dt);
        push_item(1'b0, dt, $urandom);
    endtask

    task automatic push_trigger(input int unsigned len);
        push_item(1'b1, $urandom_range(0, DELTA_MAX), len);
    endtask

    function automatic int unsigned pick_delta(input int unsigned dmax);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            return 0;
        end
        if (r == 1)
        begin
            return dmax;
        end
        return $urandom_range(0, dmax);
    endfunction

    task automatic queue_blink_run();
        int          r;
        int          n;
        int          cnt;
        int unsigned dmax;
        int unsigned len;
        int unsigned sum;
        int unsigned d;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            n    = $urandom_range(1, 24);
            dmax = ($urandom_range(0, 3) == 0) ? DELTA_MAX : $urandom_range(1, DELTA_MAX);
            len  = $urandom_range(0, n * dmax);
            if (len > TIMER_MAX)
            begin
                len = TIMER_MAX;
            end
            push_trigger(len);
            sum = 0;
            cnt = 0;
            while (sum <= len && cnt < 3 * n)
            begin
                if ($urandom_range(0, 15) == 0)
                begin
                    push_trigger($urandom_range(0, n * dmax));
                end
                d = pick_delta(dmax);
                push_tick(d);
                sum += d;
                cnt++;
            end
            if ($urandom_range(0, 99) < 85)
            begin
                push_tick(pick_delta(DELTA_MAX));
            end
        end
        else if (r < 85)
        begin
            repeat ($urandom_range(1, 6))
            begin
                push_item(1'($urandom_range(0, 1)), $urandom_range(0, DELTA_MAX), $urandom);
            end
        end
        else
        begin
            push_trigger($urandom_range(0, 3));
            repeat ($urandom_range(1, 3))
            begin
                push_tick($urandom_range(0, 2));
            end
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (stim_q.size() != 0 || req_if.valid || expected_levels.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic program_fader(input logic [asbf_pkg::CFG_W-1:0] hi,
                                 input logic [asbf_pkg::CFG_W-1:0] lo,
                                 input logic [asbf_pkg::CFG_W-1:0] fl,
                                 input logic [asbf_pkg::CFG_W-1:0] cl);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= asbf_pkg::CFG_OPACITY_HIGH;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_index <= asbf_pkg::CFG_OPACITY_LOW;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= asbf_pkg::CFG_RATE_FLOOR;
        cfg_data  <= fl;
        @(posedge clk);
        cfg_index <= asbf_pkg::CFG_RATE_CEILING;
        cfg_data  <= cl;
        @(posedge clk);
        cfg_we <= 1'b0;
        wave_hi = hi;
        wave_lo = lo;
        rate_lo = fl;
        rate_hi = cl;
        settings++;
        @(negedge clk);
    endtask

    initial
    begin : stim_proc
        int start;
        rst_n               = 1'b0;
        req_if.valid        = 1'b0;
        req_if.action       = 1'b0;
        req_if.delta_time   = '0;
        req_if.blink_length = '0;
        rsp_if.ready        = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = asbf_pkg::CFG_OPACITY_HIGH;
        cfg_data            = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed opening: zero length, extremes, retrigger, exact end and stale timer.
        push_tick(0);
        push_trigger(0);
        push_tick(0);
        push_tick(DELTA_MAX);
        push_trigger(TIMER_MAX);
        push_tick(DELTA_MAX);
        push_tick(0);
        push_tick(1);
        push_trigger(32'h020000);
        push_tick(DELTA_MAX);
        push_tick(12345);
        push_trigger(32'h030000);
        repeat (5) push_tick(32'h08000);
        push_tick(32'h07000);
        push_tick(32'h01000);
        push_trigger(100);
        push_tick(0);
        push_tick(DELTA_MAX);
        push_trigger(1);
        push_tick(0);
        push_tick(DELTA_MAX);
        wait_idle();

        for (int ph = 1; ph <= RAND_PHASES; ph++)
        begin
            case (ph)
                1: program_fader(16'd32768, 16'd0, 16'd256, 16'd2560);
                2: program_fader(16'd0, 16'd32768, 16'd0, 16'd65535);
                3: program_fader(16'd65535, 16'd65535, 16'd65535, 16'd0);
                4: program_fader(16'd20000, 16'd10000, 16'd1, 16'd100);
                5: program_fader(16'd32768, 16'd32768, 16'd256, 16'd256);
                6: program_fader(16'd0, 16'd0, 16'd0, 16'd0);
                7: program_fader(16'd65535, 16'd0, 16'd300, 16'd40000);
                default: program_fader(16'($urandom_range(0, 32768)),
                                       16'($urandom_range(0, 32768)),
                                       16'($urandom_range(0, 4096)),
                                       16'($urandom_range(0, 65535)));
            endcase
            calm  = (ph % 3 == 2);
            start = queued;
            if (ph == 1)
            begin
                // Timer saturation: a full-length blink walked in maximal frames.
                push_tick(0);
                push_trigger(TIMER_MAX);
                repeat (257) push_tick(DELTA_MAX);
            end
            while (queued - start < PHASE_ITEMS)
            begin
                queue_blink_run();
            end
            wait_idle();
        end

        $display("Checked %0d beats over %0d register settings.", beats, settings);
        $display("Triggers %0d, wave ticks %0d, blink ends %0d, idle ticks %0d, saturations %0d.",
                 n_trigger, n_wave, n_end, n_idle, n_sat);
        if (errors == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
